[src/yhac_pkg.sv]
// Shared constants for the YCbCr to HSV anomaly classifier.
// Used by ycbcr_hsv_anomaly_classifier; depends on nothing.
`default_nettype none

package yhac_pkg;

  // Hue scale in 1/32 degree.
  localparam int unsigned HUE_SECTOR = 1920;
  localparam int unsigned HUE_HALF   = 5760;
  localparam int unsigned HUE_FULL   = 11520;

  // Saturation scale.
  localparam int unsigned SAT_SCALE = 4096;

  // Field widths.
  localparam int unsigned HUE_W = 14;
  localparam int unsigned SAT_W = 13;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned CFG_W = 14;
  localparam int unsigned IDX_W = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_REF_HUE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_REF_SAT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_REF_VAL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_HUE_LIM   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SAT_LIM   = 3'd4;
  localparam logic [IDX_W-1:0] REG_VAL_LIM   = 3'd5;

  // Reset values of the limits.
  localparam logic [12:0] HUE_LIM_RST = 13'd1280;
  localparam logic [12:0] SAT_LIM_RST = 13'd1024;
  localparam logic [7:0]  VAL_LIM_RST = 8'd51;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

endpackage

`default_nettype wire

[src/yhac_recip_div.sv]
// Three-stage divider computing floor(SCALE*num/den) for 8-bit num <= den operands.
// Reciprocal table lookup and multiply, back-multiply, then one correction step.
// Standalone; the table is built at elaboration from SCALE.
`default_nettype none

module yhac_recip_div #(
  parameter int unsigned SCALE = 4096,
  parameter int unsigned QW    = $clog2(SCALE + 1)
) (
  input  wire logic          clk,
  input  wire logic [7:0]    num_i,
  input  wire logic [7:0]    den_i,
  output logic      [QW-1:0] quo_o,
  output logic               rem_nz_o
);

  localparam int unsigned MW = $clog2(SCALE * 256 + 1);
  localparam int unsigned PW = MW + 8;
  localparam int unsigned NW = $clog2(SCALE * 255 + 1);

  // Entry i holds floor(SCALE*256/i); entry zero is never used.
  logic [MW-1:0] recip [256];

  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam int unsigned RV = (i == 0) ? 0 : (SCALE * 256) / ((i == 0) ? 1 : i);
    assign recip[i] = MW'(RV);
  end

  logic [PW-1:0] prod_a_r;
  logic [7:0]    num_a_r;
  logic [7:0]    den_a_r;

  logic [QW-1:0] q0_b_r;
  logic [NW-1:0] qd_b_r;
  logic [NW-1:0] n_b_r;
  logic [7:0]    den_b_r;

  logic [QW-1:0] quo_r;
  logic          rem_nz_r;

  logic [QW-1:0] q0;
  logic [NW-1:0] rem;
  logic          ge;

  always_ff @(posedge clk) begin
    prod_a_r <= PW'(num_i) * PW'(recip[den_i]);
    num_a_r  <= num_i;
    den_a_r  <= den_i;
  end

  // The estimate is never above the true quotient and at most one below it.
  assign q0 = prod_a_r[8 +: QW];

  always_ff @(posedge clk) begin
    q0_b_r  <= q0;
    qd_b_r  <= NW'(q0) * NW'(den_a_r);
    n_b_r   <= NW'(num_a_r) * NW'(SCALE);
    den_b_r <= den_a_r;
  end

  assign rem = n_b_r - qd_b_r;
  assign ge  = rem >= NW'(den_b_r);

  always_ff @(posedge clk) begin
    if (ge) begin
      quo_r    <= q0_b_r + QW'(1);
      rem_nz_r <= rem != NW'(den_b_r);
    end else begin
      quo_r    <= q0_b_r;
      rem_nz_r <= rem != '0;
    end
  end

  assign quo_o    = quo_r;
  assign rem_nz_o = rem_nz_r;

endmodule

`default_nettype wire

[src/ycbcr_hsv_anomaly_classifier.sv]
// Top level of the YCbCr to HSV anomaly classifier.
// Depends on yhac_pkg and two instances of yhac_recip_div.
`default_nettype none

// Usage
// A request carries one pixel (in_luma, in_blue_diff, in_red_diff) and is taken
// at each rising edge where start is high and busy is low. busy is always low:
// the pipeline takes one request every clock cycle.
// Each request gives exactly one result (out_hue, out_saturation, out_value,
// out_anomalous). The result is shown for one cycle with out_strobe high, after the
// request has passed all stages, and is taken at the edge that ends that cycle.
// Results leave in request order.
// The eight stages are: color matrix, clamp, max/min and sector select, three
// divider stages (reciprocal multiply, back-multiply, correction), hue assembly,
// and the comparison against the reference. Throughput is one pixel per cycle,
// set by the fully pipelined dividers.
// The receiver cannot stall, so the pipeline never holds.
// Reset (rst_n low at a clock edge) clears all stage valid bits and loads the
// reference and limit registers with their defaults; items in flight are dropped.
// Configuration is written through cfg_we, cfg_index and cfg_data; indexes
// beyond the register list are ignored. Write only while no request is in flight.

module ycbcr_hsv_anomaly_classifier (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_luma,
  input  wire logic [7:0]  in_blue_diff,
  input  wire logic [7:0]  in_red_diff,

  output logic             out_strobe,
  output logic [13:0]      out_hue,
  output logic [12:0]      out_saturation,
  output logic [7:0]       out_value,
  output logic             out_anomalous,

  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  localparam int unsigned SAT_QW = $clog2(yhac_pkg::SAT_SCALE + 1);
  localparam int unsigned HUE_QW = $clog2(yhac_pkg::HUE_SECTOR + 1);
  localparam int unsigned DIV_LAT = 3;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [13:0] ref_hue_r;
  logic [12:0] ref_sat_r;
  logic [7:0]  ref_val_r;
  logic [12:0] hue_lim_r;
  logic [12:0] sat_lim_r;
  logic [7:0]  val_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_hue_r <= '0;
      ref_sat_r <= '0;
      ref_val_r <= '0;
      hue_lim_r <= yhac_pkg::HUE_LIM_RST;
      sat_lim_r <= yhac_pkg::SAT_LIM_RST;
      val_lim_r <= yhac_pkg::VAL_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        yhac_pkg::REG_REF_HUE: ref_hue_r <= cfg_data;
        yhac_pkg::REG_REF_SAT: ref_sat_r <= cfg_data[12:0];
        yhac_pkg::REG_REF_VAL: ref_val_r <= cfg_data[7:0];
        yhac_pkg::REG_HUE_LIM: hue_lim_r <= cfg_data[12:0];
        yhac_pkg::REG_SAT_LIM: sat_lim_r <= cfg_data[12:0];
        yhac_pkg::REG_VAL_LIM: val_lim_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The pipeline never holds, so a request is taken in every cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: color matrix
  logic               v1_r;
  logic signed [18:0] tr1_r, tg1_r, tb1_r;
  logic signed [19:0] c_s, d_s, e_s, tr_s, tg_s, tb_s;

  always_comb begin
    c_s  = 20'(signed'({1'b0, in_luma}))      - 20'sd16;
    d_s  = 20'(signed'({1'b0, in_blue_diff})) - 20'sd128;
    e_s  = 20'(signed'({1'b0, in_red_diff}))  - 20'sd128;
    tr_s = 20'sd298 * c_s + 20'sd409 * e_s + 20'sd128;
    tg_s = 20'sd298 * c_s - 20'sd100 * d_s - 20'sd208 * e_s + 20'sd128;
    tb_s = 20'sd298 * c_s + 20'sd516 * d_s + 20'sd128;
  end

  always_ff @(posedge clk) begin
    tr1_r <= tr_s[18:0];
    tg1_r <= tg_s[18:0];
    tb1_r <= tb_s[18:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divide by 256 with floor and clamp to a byte
  function automatic logic [7:0] clamp_byte(input logic signed [18:0] t);
    logic signed [10:0] q;
    q = 11'(t >>> 8);
    if (q < 0) begin
      clamp_byte = 8'd0;
    end else if (q > 11'sd255) begin
      clamp_byte = 8'd255;
    end else begin
      clamp_byte = q[7:0];
    end
  endfunction

  logic       v2_r;
  logic [7:0] r2_r, g2_r, b2_r;

  always_ff @(posedge clk) begin
    r2_r <= clamp_byte(tr1_r);
    g2_r <= clamp_byte(tg1_r);
    b2_r <= clamp_byte(tb1_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: max, min, sector and hue numerator
  logic                v3_r;
  logic [7:0]          mx3_r, d3_r, a3_r;
  logic                neg3_r;
  yhac_pkg::sector_t   sec3_r;

  logic [7:0]          mx_c, mn_c;
  logic signed [8:0]   diff_c;
  yhac_pkg::sector_t   sec_c;

  always_comb begin
    mx_c = r2_r;
    mn_c = r2_r;
    if (g2_r > mx_c) mx_c = g2_r;
    if (b2_r > mx_c) mx_c = b2_r;
    if (g2_r < mn_c) mn_c = g2_r;
    if (b2_r < mn_c) mn_c = b2_r;
    // Ties go to red first, then green.
    priority if (mx_c == r2_r) begin
      sec_c  = yhac_pkg::SEC_RED;
      diff_c = signed'({1'b0, g2_r}) - signed'({1'b0, b2_r});
    end else if (mx_c == g2_r) begin
      sec_c  = yhac_pkg::SEC_GREEN;
      diff_c = signed'({1'b0, b2_r}) - signed'({1'b0, r2_r});
    end else begin
      sec_c  = yhac_pkg::SEC_BLUE;
      diff_c = signed'({1'b0, r2_r}) - signed'({1'b0, g2_r});
    end
  end

  always_ff @(posedge clk) begin
    mx3_r  <= mx_c;
    d3_r   <= mx_c - mn_c;
    neg3_r <= diff_c[8];
    a3_r   <= diff_c[8] ? 8'(-diff_c) : diff_c[7:0];
    sec3_r <= sec_c;
  end

  // ---------------------------------------------------------------------------
  // Stages 4 to 6: dividers
  logic [SAT_QW-1:0] sat_q;
  logic              sat_rnz;
  logic [HUE_QW-1:0] hue_q;
  logic              hue_rnz;

  yhac_recip_div #(
    .SCALE (yhac_pkg::SAT_SCALE)
  ) u_sat_div (
    .clk      (clk),
    .num_i    (d3_r),
    .den_i    (mx3_r),
    .quo_o    (sat_q),
    .rem_nz_o (sat_rnz)
  );

  yhac_recip_div #(
    .SCALE (yhac_pkg::HUE_SECTOR)
  ) u_hue_div (
    .clk      (clk),
    .num_i    (a3_r),
    .den_i    (d3_r),
    .quo_o    (hue_q),
    .rem_nz_o (hue_rnz)
  );

  // Side data delayed alongside the dividers.
  logic [DIV_LAT-1:0] vd_r;
  logic [7:0]         mxd_r   [DIV_LAT];
  logic               dzd_r   [DIV_LAT];
  logic               negd_r  [DIV_LAT];
  yhac_pkg::sector_t  secd_r  [DIV_LAT];

  always_ff @(posedge clk) begin
    mxd_r[0]  <= mx3_r;
    dzd_r[0]  <= d3_r == '0;
    negd_r[0] <= neg3_r;
    secd_r[0] <= sec3_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      mxd_r[i]  <= mxd_r[i-1];
      dzd_r[i]  <= dzd_r[i-1];
      negd_r[i] <= negd_r[i-1];
      secd_r[i] <= secd_r[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: hue assembly
  logic        v7_r;
  logic [13:0] hue7_r;
  logic [12:0] sat7_r;
  logic [7:0]  val7_r;

  logic [14:0] base_c, ceil_c, hue_c;
  logic        neg_l;
  logic [7:0]  mx_l;

  assign neg_l = negd_r[DIV_LAT-1];
  assign mx_l  = mxd_r[DIV_LAT-1];

  always_comb begin
    // A negative numerator floors to minus the rounded-up magnitude.
    ceil_c = 15'(hue_q) + 15'(hue_rnz);
    unique case (secd_r[DIV_LAT-1])
      yhac_pkg::SEC_RED:   base_c = neg_l ? 15'(yhac_pkg::HUE_FULL) : 15'd0;
      yhac_pkg::SEC_GREEN: base_c = 15'(2 * yhac_pkg::HUE_SECTOR);
      default:             base_c = 15'(4 * yhac_pkg::HUE_SECTOR);
    endcase
    if (dzd_r[DIV_LAT-1]) begin
      hue_c = '0;
    end else if (neg_l) begin
      hue_c = base_c - ceil_c;
    end else begin
      hue_c = base_c + 15'(hue_q);
    end
  end

  always_ff @(posedge clk) begin
    hue7_r <= hue_c[13:0];
    sat7_r <= (mx_l == '0) ? '0 : 13'(sat_q);
    val7_r <= mx_l;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: compare with the reference
  logic        v8_r;
  logic [13:0] hue8_r;
  logic [12:0] sat8_r;
  logic [7:0]  val8_r;
  logic        anom8_r;

  logic signed [15:0] hdiff_c, hfold_c;
  logic [13:0]        hdist_c;
  logic [12:0]        sdist_c;
  logic [7:0]         vdist_c;
  logic               anom_c;

  always_comb begin
    hdiff_c = 16'(signed'({1'b0, hue7_r})) - 16'(signed'({1'b0, ref_hue_r}));
    hdist_c = hdiff_c[15] ? 14'(-hdiff_c) : hdiff_c[13:0];
    // Fold to the short way around; an out-of-range reference may go negative.
    if (hdist_c > 14'(yhac_pkg::HUE_HALF)) begin
      hfold_c = 16'(signed'(17'(yhac_pkg::HUE_FULL))) - 16'(signed'({2'b00, hdist_c}));
    end else begin
      hfold_c = 16'(signed'({2'b00, hdist_c}));
    end
    sdist_c = (sat7_r > ref_sat_r) ? sat7_r - ref_sat_r : ref_sat_r - sat7_r;
    vdist_c = (val7_r > ref_val_r) ? val7_r - ref_val_r : ref_val_r - val7_r;
    anom_c  = (!hfold_c[15] && (hfold_c[14:0] > 15'(hue_lim_r)))
           || (sdist_c > sat_lim_r)
           || (vdist_c > val_lim_r);
  end

  always_ff @(posedge clk) begin
    hue8_r  <= hue7_r;
    sat8_r  <= sat7_r;
    val8_r  <= val7_r;
    anom8_r <= anom_c;
  end

  // ---------------------------------------------------------------------------
  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vd_r <= '0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vd_r <= {vd_r[DIV_LAT-2:0], v3_r};
      v7_r <= vd_r[DIV_LAT-1];
      v8_r <= v7_r;
    end
  end

  assign out_strobe     = v8_r;
  assign out_hue        = hue8_r;
  assign out_saturation = sat8_r;
  assign out_value      = val8_r;
  assign out_anomalous  = anom8_r;

  // ---------------------------------------------------------------------------
  // Assertions
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_hue < 14'(yhac_pkg::HUE_FULL)))
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_saturation <= 13'(yhac_pkg::SAT_SCALE)))
    else $error("saturation out of range");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_saturation == '0)) |-> (out_hue == '0))
    else $error("gray pixel with nonzero hue");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_value == '0)) |-> (out_saturation == '0))
    else $error("black pixel with nonzero saturation");

  // A power-of-two maximum divides the scaled saturation exactly.
  a_sat_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (vd_r[DIV_LAT-1] && (mx_l != '0) && ((mx_l & (mx_l - 8'd1)) == '0)) |-> !sat_rnz)
    else $error("saturation remainder with a power-of-two maximum");

endmodule

`default_nettype wire
